// ===== rtl/core/flrs_pkg.sv =====
// flrs_pkg: types, constants and helper functions for the flash log record scanner
// no dependencies; imported by flash_log_record_scanner
`default_nettype none

package flrs_pkg;

  // width of the scan position counter
  localparam int unsigned ADDR_WIDTH = 17;
  // width of reported flash offsets and of the gap total
  localparam int unsigned OFS_W      = 17;
  localparam int unsigned SUM_W      = (ADDR_WIDTH > OFS_W) ? ADDR_WIDTH : OFS_W;
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);
  // result queue entries
  localparam int unsigned QDEPTH     = 3;

  typedef logic [ADDR_WIDTH-1:0] pos_t;
  typedef logic [OFS_W-1:0]      ofs_t;

  localparam pos_t POS_MAX  = {ADDR_WIDTH{1'b1}};
  localparam ofs_t GAP_MAX  = {OFS_W{1'b1}};
  localparam pos_t MAGIC_LEN = pos_t'(HDR_BYTES);

  localparam logic [7:0] ERASED_BYTE = 8'hff;
  localparam logic [7:0] CRC_POLY    = 8'h31;

  // header byte positions
  localparam logic [HDR_IDX_W-1:0] HDR_INV_LO  = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] HDR_INV_HI  = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] HDR_CRC     = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_NAME    = HDR_IDX_W'(5);
  localparam logic [HDR_IDX_W-1:0] HDR_DLEN_LO = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST    = HDR_IDX_W'(7);

  // eight-byte ascii root magic of the log
  localparam logic [7:0] ROOT_MAGIC [HDR_BYTES] = '{
    8'h5f, 8'h46, 8'h53, 8'h33, 8'h5f, 8'h4c, 8'h4f, 8'h47
  };

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_HEADER = 3'd1,
    PH_NAME   = 3'd2,
    PH_DATA   = 3'd3,
    PH_TRAIL  = 3'd4,
    PH_DONE   = 3'd5
  } scan_phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CRC    = 3'd1,
    ST_TRAIL_FLIP = 3'd2,
    ST_NO_MAGIC   = 3'd3,
    ST_TRUNCATED  = 3'd4
  } scan_status_e;

  typedef enum logic {
    KIND_RECORD  = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] flash_byte;
    logic       region_end;
  } in_t;

  typedef struct packed {
    result_kind_e result_kind;
    scan_status_e scan_status;
    ofs_t         where_offset;
    logic         record_live;
    logic [7:0]   name_bytes;
    logic [15:0]  data_bytes;
    ofs_t         gap_total;
    logic         last_of_run;
  } out_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // relative scan position to absolute flash offset, wrapping
  function automatic ofs_t abs_ofs(input ofs_t root, input pos_t rel);
    logic [SUM_W-1:0] s;
    s = SUM_W'(root) + SUM_W'(rel);
    return s[OFS_W-1:0];
  endfunction

  function automatic out_t mk_res(input result_kind_e kind, input scan_status_e st,
                                  input ofs_t where, input logic live,
                                  input logic [7:0] name, input logic [15:0] data,
                                  input ofs_t gap);
    out_t r;
    r.result_kind  = kind;
    r.scan_status  = st;
    r.where_offset = where;
    r.record_live  = live;
    r.name_bytes   = name;
    r.data_bytes   = data;
    r.gap_total    = gap;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/flash_log_record_scanner.sv =====
// flash_log_record_scanner: walks a flash log byte stream and reports records and a summary
// depends on flrs_pkg (types, magic table, crc and offset helpers)
// a result is registered into the result queue when the byte that causes it is accepted
// throughput: one byte per cycle; a byte causing two results puts both into
//   a three-entry result queue, so input stalls only on output backpressure
// reset: rst_ni (async, low) clears the scan state, the queue and root_offset;
//   the header byte store is not cleared, each entry is written before it is read
`default_nettype none

module flash_log_record_scanner
  import flrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // configuration: root_offset
  input  wire logic        cfg_we_i,
  input  wire logic [OFS_W-1:0] cfg_wdata_i,
  // flash byte stream
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  // results
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  // ---------------------------------------------------------------------------
  // scan state
  // ---------------------------------------------------------------------------
  ofs_t        root_q;
  scan_phase_e ph_q, ph_d;
  pos_t        pos_q, pos_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  crc_q, crc_d;
  pos_t        rs_q, rs_d;       // current record / header start
  ofs_t        gap_q, gap_d;
  logic        aes_q, aes_d;     // all header bytes so far were erased
  logic [7:0]  hdr_q [HDR_BYTES];
  logic [7:0]  hdr_n [HDR_BYTES]; // header store including the byte being taken
  logic        hdr_we;

  // result queue
  out_t        q_q [QDEPTH];
  out_t        q_d [QDEPTH];
  logic [1:0]  fcnt_q, fcnt_d;
  logic [1:0]  base;
  logic        pop, acc;

  // per-transaction results
  out_t        res0, res1, r;
  logic [1:0]  n_res;
  logic        fin;
  pos_t        nxt;
  logic [7:0]  b;
  logic [15:0] dlen;
  logic        live;
  logic [17:0] gsum;

  assign b   = in_data_i.flash_byte;
  assign pop = out_valid_o & out_ready_i;
  assign base = fcnt_q - {1'b0, pop};
  // room for two more results after this cycle's pop
  assign in_ready_o = (base <= 2'd1);
  assign acc = in_valid_i & in_ready_o;

  assign out_valid_o = (fcnt_q != 2'd0);
  assign out_data_o  = q_q[0];

  // header store view with the current header byte merged in
  always_comb begin
    hdr_we = (ph_q == PH_HEADER);
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_n[i] = (hdr_we && cnt_q[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) ? b : hdr_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // per-byte parse: next state and up to two results
  // ---------------------------------------------------------------------------
  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    crc_d = crc_q;
    rs_d  = rs_q;
    gap_d = gap_q;
    aes_d = aes_q;
    fin   = 1'b0;
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    r     = '0;
    gsum  = '0;
    nxt   = (pos_q == POS_MAX) ? POS_MAX : pos_q + pos_t'(1);
    pos_d = nxt;
    dlen  = {hdr_n[HDR_LAST], hdr_n[HDR_DLEN_LO]};
    live  = (hdr_n[HDR_INV_LO] == ERASED_BYTE) && (hdr_n[HDR_INV_HI] == ERASED_BYTE);

    unique case (ph_q)
      PH_MAGIC: begin
        if (b != ROOT_MAGIC[cnt_q[HDR_IDX_W-1:0]]) begin
          r = mk_res(KIND_SUMMARY, ST_NO_MAGIC, abs_ofs(root_q, MAGIC_LEN), 1'b0,
                     8'd0, 16'd0, gap_d);
          res0 = r;
          n_res = 2'd1;
          ph_d = PH_DONE;
        end else if (cnt_q >= 16'(HDR_BYTES - 1)) begin
          ph_d  = PH_HEADER;
          cnt_d = '0;
          aes_d = 1'b1;
          rs_d  = nxt;
        end else begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      PH_HEADER: begin
        if (b != ERASED_BYTE) aes_d = 1'b0;
        cnt_d = cnt_q + 16'd1;
        if (cnt_q[HDR_IDX_W-1:0] == HDR_LAST) begin
          crc_d = '0;
          if (hdr_n[HDR_NAME] == ERASED_BYTE) begin
            // end marker: erased header means clean end of log
            if (!aes_d) begin
              r = mk_res(KIND_SUMMARY, ST_TRAIL_FLIP, abs_ofs(root_q, rs_q), 1'b0,
                         8'd0, 16'd0, gap_d);
              res0 = r;
              n_res = 2'd1;
              ph_d = PH_DONE;
            end else begin
              ph_d = PH_TRAIL;
            end
          end else if (hdr_n[HDR_NAME] != 8'd0) begin
            ph_d  = PH_NAME;
            cnt_d = {8'd0, hdr_n[HDR_NAME]};
          end else if (dlen != 16'd0) begin
            ph_d  = PH_DATA;
            cnt_d = dlen;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PH_NAME: begin
        cnt_d = cnt_q - 16'd1;
        if (cnt_d == 16'd0) begin
          if (dlen != 16'd0) begin
            ph_d  = PH_DATA;
            cnt_d = dlen;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PH_DATA: begin
        crc_d = crc8_byte(crc_q, b);
        cnt_d = cnt_q - 16'd1;
        if (cnt_d == 16'd0) fin = 1'b1;
      end
      PH_TRAIL: begin
        if (b != ERASED_BYTE) begin
          r = mk_res(KIND_SUMMARY, ST_TRAIL_FLIP, abs_ofs(root_q, rs_q), 1'b0,
                     8'd0, 16'd0, gap_d);
          res0 = r;
          n_res = 2'd1;
          ph_d = PH_DONE;
        end
      end
      PH_DONE: begin
        // bytes ignored until the region ends
      end
      default: begin
        ph_d = PH_DONE;
      end
    endcase

    // record complete: check crc, account gap, report
    if (fin) begin
      if (crc_d != hdr_n[HDR_CRC]) begin
        res0 = mk_res(KIND_RECORD, ST_BAD_CRC, abs_ofs(root_q, rs_q), live,
                      hdr_n[HDR_NAME], dlen, gap_d);
        res1 = mk_res(KIND_SUMMARY, ST_BAD_CRC, abs_ofs(root_q, rs_q), 1'b0,
                      8'd0, 16'd0, gap_d);
        n_res = 2'd2;
        ph_d = PH_DONE;
      end else begin
        if (!live) begin
          gsum  = 18'(gap_q) + 18'(HDR_BYTES) + 18'(hdr_n[HDR_NAME]) + 18'(dlen);
          gap_d = (gsum > 18'(GAP_MAX)) ? GAP_MAX : gsum[OFS_W-1:0];
        end
        res0 = mk_res(KIND_RECORD, ST_OK, abs_ofs(root_q, rs_q), live,
                      hdr_n[HDR_NAME], dlen, gap_d);
        n_res = 2'd1;
        ph_d  = PH_HEADER;
        cnt_d = '0;
        aes_d = 1'b1;
        rs_d  = nxt;
      end
    end

    // region end closes the scan with a summary unless one was already given
    if (in_data_i.region_end) begin
      r = '0;
      unique case (ph_d)
        PH_MAGIC: begin
          r = mk_res(KIND_SUMMARY, ST_NO_MAGIC, abs_ofs(root_q, MAGIC_LEN), 1'b0,
                     8'd0, 16'd0, gap_d);
        end
        PH_HEADER: begin
          priority if (cnt_d == 16'd0 || aes_d) begin
            r = mk_res(KIND_SUMMARY, ST_OK, abs_ofs(root_q, rs_d), 1'b0,
                       8'd0, 16'd0, gap_d);
          end else if (cnt_d > 16'd5 && hdr_n[HDR_NAME] == ERASED_BYTE) begin
            r = mk_res(KIND_SUMMARY, ST_TRAIL_FLIP, abs_ofs(root_q, rs_d), 1'b0,
                       8'd0, 16'd0, gap_d);
          end else begin
            r = mk_res(KIND_SUMMARY, ST_TRUNCATED, abs_ofs(root_q, rs_d), 1'b0,
                       8'd0, 16'd0, gap_d);
          end
        end
        PH_NAME, PH_DATA: begin
          r = mk_res(KIND_SUMMARY, ST_TRUNCATED, abs_ofs(root_q, rs_d), 1'b0,
                     8'd0, 16'd0, gap_d);
        end
        PH_TRAIL: begin
          r = mk_res(KIND_SUMMARY, ST_OK, abs_ofs(root_q, rs_d), 1'b0,
                     8'd0, 16'd0, gap_d);
        end
        default: begin
          r = '0;
        end
      endcase
      if (ph_d != PH_DONE) begin
        if (n_res == 2'd0) res0 = r;
        else res1 = r;
        n_res = n_res + 2'd1;
      end
      // fresh scan from the root on the next byte
      ph_d  = PH_MAGIC;
      pos_d = '0;
      cnt_d = '0;
      crc_d = '0;
      rs_d  = '0;
      gap_d = '0;
      aes_d = 1'b1;
    end

    // flag the last result of this byte
    if (n_res == 2'd1) res0.last_of_run = 1'b1;
    if (n_res == 2'd2) res1.last_of_run = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // result queue: entry 0 drives the output, shift on pop, append behind
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) q_d[i] = q_q[i];
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_d[i] = q_q[i+1];
    end
    fcnt_d = base;
    if (acc) begin
      if (n_res != 2'd0) q_d[base] = res0;
      if (n_res == 2'd2) q_d[base + 2'd1] = res1;
      fcnt_d = base + n_res;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      ph_q   <= PH_MAGIC;
      pos_q  <= '0;
      cnt_q  <= '0;
      crc_q  <= '0;
      rs_q   <= '0;
      gap_q  <= '0;
      aes_q  <= 1'b1;
      fcnt_q <= '0;
    end else begin
      if (cfg_we_i) root_q <= cfg_wdata_i;
      fcnt_q <= fcnt_d;
      if (acc) begin
        ph_q  <= ph_d;
        pos_q <= pos_d;
        cnt_q <= cnt_d;
        crc_q <= crc_d;
        rs_q  <= rs_d;
        gap_q <= gap_d;
        aes_q <= aes_d;
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) q_q[i] <= q_d[i];
    if (acc && hdr_we) hdr_q[cnt_q[HDR_IDX_W-1:0]] <= b;
  end

endmodule

`default_nettype wire

// ===== tb/flrs_tb_pkg.sv =====
// flrs_tb_pkg: expected-result tracking for the flash log record scanner testbench
// depends on flrs_pkg for the port structs, phase and status enums and header layout
package flrs_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import flrs_pkg::*;

  // ascii root magic, first byte in the top lane
  localparam logic [63:0] LOG_MAGIC = 64'h5f46_5333_5f4c_4f47;
  localparam logic [7:0]  CRC8_POLY = 8'h31;

  function automatic logic [7:0] magic_byte(input int idx);
    return LOG_MAGIC[63 - 8 * idx -: 8];
  endfunction

  // crc-8 msb first, one byte at a time
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC8_POLY : 8'h00);
    return r;
  endfunction

  class scan_result_predictor;
    ofs_t        root_ofs;
    scan_phase_e phase;
    pos_t        pos;
    logic [15:0] fcount;
    logic [7:0]  hdr [8];
    logic [7:0]  data_crc;
    pos_t        rec_start;
    ofs_t        gap;
    logic        erased;
    out_t        pending_reports [$];
    int unsigned errors;

    function new();
      root_ofs = '0;
      errors   = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      restart();
    endfunction

    function void restart();
      phase     = PH_MAGIC;
      pos       = '0;
      fcount    = '0;
      data_crc  = 8'h00;
      rec_start = '0;
      gap       = '0;
      erased    = 1'b1;
    endfunction

    function ofs_t flash_ofs(input pos_t rel);
      return ofs_t'(root_ofs + rel);
    endfunction

    function void post(input result_kind_e kind, input scan_status_e st, input ofs_t where,
                       input logic live, input logic [7:0] nm, input logic [15:0] dl);
      out_t r;
      r.result_kind  = kind;
      r.scan_status  = st;
      r.where_offset = where;
      r.record_live  = live;
      r.name_bytes   = nm;
      r.data_bytes   = dl;
      r.gap_total    = gap;
      r.last_of_run  = 1'b0;
      pending_reports = {pending_reports, r};
    endfunction

    function void post_summary(input scan_status_e st, input ofs_t where);
      post(KIND_SUMMARY, st, where, 1'b0, 8'h00, 16'h0000);
    endfunction

    function void open_header(input pos_t nxt);
      phase     = PH_HEADER;
      fcount    = '0;
      erased    = 1'b1;
      rec_start = nxt;
    endfunction

    function logic [15:0] data_len();
      return {hdr[HDR_LAST], hdr[HDR_DLEN_LO]};
    endfunction

    function void close_record(input pos_t nxt);
      logic        live;
      logic [17:0] g;
      live = (hdr[HDR_INV_LO] == ERASED_BYTE) && (hdr[HDR_INV_HI] == ERASED_BYTE);
      if (data_crc != hdr[HDR_CRC]) begin
        post(KIND_RECORD, ST_BAD_CRC, flash_ofs(rec_start), live, hdr[HDR_NAME], data_len());
        post_summary(ST_BAD_CRC, flash_ofs(rec_start));
        phase = PH_DONE;
        return;
      end
      if (!live) begin
        g   = 18'(gap) + 18'd8 + 18'(hdr[HDR_NAME]) + 18'(data_len());
        gap = (g > 18'(GAP_MAX)) ? GAP_MAX : g[OFS_W-1:0];
      end
      post(KIND_RECORD, ST_OK, flash_ofs(rec_start), live, hdr[HDR_NAME], data_len());
      open_header(nxt);
    endfunction

    // one accepted byte transaction
    function void take_flash_byte(input in_t item);
      logic [7:0] b;
      pos_t       nxt;
      int         first;
      b     = item.flash_byte;
      first = pending_reports.size();
      nxt   = (pos != POS_MAX) ? pos + pos_t'(1) : POS_MAX;
      pos   = nxt;
      case (phase)
        PH_MAGIC: begin
          if (b != magic_byte(int'(fcount[2:0]))) begin
            post_summary(ST_NO_MAGIC, flash_ofs(MAGIC_LEN));
            phase = PH_DONE;
          end else if (fcount >= 16'd7) begin
            open_header(nxt);
          end else begin
            fcount = fcount + 16'd1;
          end
        end
        PH_HEADER: begin
          hdr[fcount[2:0]] = b;
          if (b != ERASED_BYTE) erased = 1'b0;
          fcount = fcount + 16'd1;
          if (fcount >= 16'd8) begin
            data_crc = 8'h00;
            if (hdr[HDR_NAME] == ERASED_BYTE) begin
              if (!erased) begin
                post_summary(ST_TRAIL_FLIP, flash_ofs(rec_start));
                phase = PH_DONE;
              end else begin
                phase = PH_TRAIL;
              end
            end else if (hdr[HDR_NAME] != 8'h00) begin
              phase  = PH_NAME;
              fcount = {8'h00, hdr[HDR_NAME]};
            end else if (data_len() != 16'h0000) begin
              phase  = PH_DATA;
              fcount = data_len();
            end else begin
              close_record(nxt);
            end
          end
        end
        PH_NAME: begin
          fcount = fcount - 16'd1;
          if (fcount == 16'd0) begin
            if (data_len() != 16'h0000) begin
              phase  = PH_DATA;
              fcount = data_len();
            end else begin
              close_record(nxt);
            end
          end
        end
        PH_DATA: begin
          data_crc = crc8_next(data_crc, b);
          fcount   = fcount - 16'd1;
          if (fcount == 16'd0) close_record(nxt);
        end
        PH_TRAIL: begin
          if (b != ERASED_BYTE) begin
            post_summary(ST_TRAIL_FLIP, flash_ofs(rec_start));
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
      if (item.region_end) begin
        case (phase)
          PH_MAGIC: post_summary(ST_NO_MAGIC, flash_ofs(MAGIC_LEN));
          PH_HEADER: begin
            if (fcount == 16'd0 || erased)
              post_summary(ST_OK, flash_ofs(rec_start));
            else if (fcount > 16'd5 && hdr[HDR_NAME] == ERASED_BYTE)
              post_summary(ST_TRAIL_FLIP, flash_ofs(rec_start));
            else
              post_summary(ST_TRUNCATED, flash_ofs(rec_start));
          end
          PH_NAME, PH_DATA: post_summary(ST_TRUNCATED, flash_ofs(rec_start));
          PH_TRAIL: post_summary(ST_OK, flash_ofs(rec_start));
          default: ;
        endcase
        restart();
      end
      if (pending_reports.size() > first)
        pending_reports[pending_reports.size() - 1].last_of_run = 1'b1;
    endfunction

    function void compare_field(input string what, input logic [31:0] exp,
                                input logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp, act);
      end
    endfunction

    // one accepted result transaction
    function void match_result(input out_t got);
      out_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      compare_field("scan_status", 32'(want.scan_status), 32'(got.scan_status));
      compare_field("where_offset", 32'(want.where_offset), 32'(got.where_offset));
      compare_field("record_live", 32'(want.record_live), 32'(got.record_live));
      compare_field("name_bytes", 32'(want.name_bytes), 32'(got.name_bytes));
      compare_field("data_bytes", 32'(want.data_bytes), 32'(got.data_bytes));
      compare_field("gap_total", 32'(want.gap_total), 32'(got.gap_total));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// tb: self-checking bench for flash_log_record_scanner, built log images in, reports checked
// depends on flrs_pkg (port types) and flrs_tb_pkg (result predictor)
// stimulus is directed scans, random log images in several root offsets, and one long log
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flrs_pkg::*;
  import flrs_tb_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 100;
  localparam int unsigned DRAIN_WAIT  = 6;
  localparam ofs_t        ROOT_TOP    = ofs_t'(131070);

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_COMB,
    RX_LONG
  } rx_pattern_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  ofs_t cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  scan_result_predictor predictor;

  // log image under construction, one scan's region
  logic [7:0]  img [$];
  int          burst_left;
  bit          calm;

  int unsigned rx_tick;
  rx_pattern_e rx_mode;
  int          rx_run;
  bit          rx_hold;
  int unsigned stuck;

  flash_log_record_scanner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side: every accepted transaction goes to the predictor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) predictor.match_result(out_data_o);
  end

  // receiver backpressure from one of four randomly chosen patterns
  always @(negedge clk_i) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 256 == 0) rx_mode = rx_pattern_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_ready_i <= 1'b1;
      RX_COIN: out_ready_i <= ($urandom_range(0, 9) < 7);
      RX_COMB: out_ready_i <= ((rx_tick % 7) >= 3);
      default: begin
        // long runs of stall and of ready
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run  = $urandom_range(1, 25);
        end
        rx_run--;
        out_ready_i <= rx_hold;
      end
    endcase
  end

  // hang detector: counts cycles with no transaction on either side
  initial begin
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        stuck = 0;
      else
        stuck++;
    end
    $display("Some tests failed");
    $finish;
  end

  // one byte transaction, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int  gap_len;
    in_t item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len    = calm ? 0 : $urandom_range(0, 12);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(negedge clk_i);
      end
    end
    burst_left--;
    item.flash_byte = b;
    item.region_end = fin;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.take_flash_byte(item);
    @(negedge clk_i);
  endtask

  // the last byte of the image carries region_end
  task automatic send_scan();
    foreach (img[i]) push_byte(img[i], i == img.size() - 1);
  endtask

  // hold the sender until every expected result is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predictor.pending_reports.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_root(input ofs_t value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    predictor.root_ofs = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic append_byte(input logic [7:0] b);
    img = {img, b};
  endtask

  task automatic push_magic();
    for (int i = 0; i < 8; i++) append_byte(magic_byte(i));
  endtask

  task automatic trim_to(input int keep);
    if (img.size() > keep) img = img[0:keep-1];
  endtask

  // header, name and data of one record; crc is right unless asked otherwise
  task automatic add_record(input bit live, input int nm, input int dl, input bit bad_crc);
    logic [7:0] body [$];
    logic [7:0] sum;
    logic [7:0] inv_lo;
    logic [7:0] inv_hi;
    sum = 8'h00;
    for (int i = 0; i < dl; i++) begin
      body = {body, 8'($urandom)};
      sum = crc8_next(sum, body[i]);
    end
    if (bad_crc) sum = sum ^ 8'($urandom_range(1, 255));
    if (live) begin
      inv_lo = ERASED_BYTE;
      inv_hi = ERASED_BYTE;
    end else begin
      inv_lo = 8'($urandom);
      inv_hi = 8'($urandom);
      if (inv_lo == ERASED_BYTE && inv_hi == ERASED_BYTE) inv_hi = 8'h00;
    end
    append_byte(inv_lo);
    append_byte(inv_hi);
    append_byte(sum);
    append_byte(8'($urandom));
    append_byte(8'($urandom));
    append_byte(8'(nm));
    append_byte(8'(dl));
    append_byte(8'(dl >> 8));
    repeat (nm) append_byte(8'($urandom));
    foreach (body[i]) append_byte(body[i]);
  endtask

  // end marker is an all-erased header; a flip never touches the name length
  task automatic add_end_marker(input bit flip);
    int at;
    at = img.size();
    repeat (8) append_byte(ERASED_BYTE);
    if (flip) begin
      at = at + (($urandom_range(0, 6) + 6) % 7 == 5 ? 7 : $urandom_range(0, 4));
      img[at] = ERASED_BYTE ^ 8'($urandom_range(1, 255));
    end
  endtask

  // mostly short names, now and then a long one
  function automatic int pick_name_len();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom_range(200, 254);
    if (r < 12) return 0;
    return $urandom_range(1, 4);
  endfunction

  function automatic int pick_data_len();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom_range(100, 300);
    if (r < 8) return 0;
    return $urandom_range(1, 8);
  endfunction

  // one random region: mostly a sound log, some noise, damage and cut-offs
  task automatic build_scan();
    int roll;
    int idx;
    int trail;
    img.delete();
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // plain noise, almost always dies in the magic
      repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      return;
    end
    push_magic();
    if (roll < 11) begin
      idx = $urandom_range(0, 7);
      img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
    end
    repeat ($urandom_range(0, 3))
      add_record($urandom_range(0, 2) != 0, pick_name_len(), pick_data_len(),
                 $urandom_range(0, 14) == 0);
    case ($urandom_range(0, 9))
      0: ;  // region stops on a record boundary
      1: begin
        // damaged end marker whose region ends after the name length byte
        add_end_marker(1'b1);
        trim_to(img.size() - $urandom_range(1, 2));
      end
      default: begin
        add_end_marker($urandom_range(0, 7) == 0);
        trail = $urandom_range(0, 6);
        repeat (trail) append_byte(ERASED_BYTE);
        if (trail != 0 && $urandom_range(0, 4) == 0) begin
          idx = img.size() - 1 - $urandom_range(0, trail - 1);
          img[idx] = ERASED_BYTE ^ 8'($urandom_range(1, 255));
        end
      end
    endcase
    // cut-off anywhere, magic and headers included
    if ($urandom_range(0, 6) == 0) trim_to($urandom_range(1, img.size()));
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned sent;
    sent = 0;
    calm = ($urandom_range(0, 3) == 0);
    while (sent < budget) begin
      build_scan();
      send_scan();
      sent += img.size();
      if ($urandom_range(0, 7) == 0) drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b1;
    burst_left  = 0;
    calm        = 1'b0;
    rx_tick     = 0;
    rx_mode     = RX_OPEN;
    rx_run      = 0;
    rx_hold     = 1'b0;
    predictor   = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed scans at the top root offset, so offsets wrap
    set_root(ROOT_TOP);
    img = '{8'h00};
    send_scan();
    img.delete();
    push_magic();
    send_scan();
    img.delete();
    push_magic();
    trim_to(3);
    send_scan();
    // invalidated empty record and region end on its last header byte
    img.delete();
    push_magic();
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(ERASED_BYTE);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h00);
    send_scan();

    // random logs across root offsets, extremes and odd ones included
    set_root('0);
    run_random(PHASE_BYTES);
    set_root(ofs_t'(1));
    run_random(PHASE_BYTES);
    set_root(ofs_t'($urandom_range(2, 131069)));
    run_random(PHASE_BYTES);
    set_root(ROOT_TOP);
    run_random(PHASE_BYTES);

    // one long log: longest name length with a long data field, sent without gaps
    set_root(ofs_t'($urandom_range(0, 131070)));
    calm = 1'b1;
    img.delete();
    push_magic();
    add_record(1'b0, 254, 120, 1'b0);
    add_record(1'b1, 3, 5, 1'b0);
    add_end_marker(1'b0);
    append_byte(ERASED_BYTE);
    append_byte(ERASED_BYTE);
    send_scan();
    calm = 1'b0;

    set_root(ofs_t'($urandom_range(0, 131070)));
    run_random(PHASE_BYTES);

    drain();
    if (predictor.errors == 0 && predictor.pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== flash_log_record_scanner.f =====
rtl/core/flrs_pkg.sv
rtl/core/flash_log_record_scanner.sv
tb/flrs_tb_pkg.sv
tb/tb.sv
